// ----- rtl/core/kwsum_pkg.sv -----
// kwsum_pkg: shared types and constants of the k-way sorted union merge unit
// no dependencies; used by the channel interfaces and the top level

package kwsum_pkg;

  // default sizing handed to the top level parameters
  localparam int unsigned NUM_LISTS_DEF  = 16;
  localparam int unsigned LIST_DEPTH_DEF = 64;

  // field widths fixed by the request and result formats
  localparam int unsigned REQ_W = 2;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned VAL_W = 31;

  // digit-serial compare: digit width, digit count and padded shift width
  localparam int unsigned DIG_W  = 8;
  localparam int unsigned DIGITS = (VAL_W + DIG_W - 1) / DIG_W;
  localparam int unsigned SHW    = DIGITS * DIG_W;
  localparam int unsigned DCW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

endpackage

// ----- rtl/core/kwsum_if.sv -----
// kwsum_req_if / kwsum_res_if: valid-ready channels of the merge unit
// depends on kwsum_pkg for the field widths

interface kwsum_req_if;
  import kwsum_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] list_index;
  logic [VAL_W-1:0] value;

  modport source (output valid, req_type, list_index, value, input ready);
  modport sink   (input valid, req_type, list_index, value, output ready);
endinterface

interface kwsum_res_if;
  import kwsum_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] merged_value;
  logic             valid_res;
  logic             overflow;

  modport source (output valid, merged_value, valid_res, overflow, input ready);
  modport sink   (input valid, merged_value, valid_res, overflow, output ready);
endinterface

// ----- rtl/core/k_way_sorted_union_merge_unit.sv -----
// k_way_sorted_union_merge_unit: sorted union of NUM_LISTS ascending lists
// depends on kwsum_pkg and the channel interfaces in kwsum_if.sv

// Each request beat gives exactly one result beat. A push or a clear is taken
// in the idle state and its result is registered the next cycle. A pop walks
// the lists one after another: S_SCAN checks each list's fill count, and a
// non-empty list goes on to S_LOAD for the buffer memory read and to S_CMP, in
// which its head is compared with the running minimum one 8-bit digit per
// cycle over DIGITS (4) digits, most significant first. The list memory has a
// single read port and the comparator is serial, so a pop handles the lists
// one at a time. Lists whose head equals the minimum are all advanced at the
// end of the pop, so a shared value comes out once. A new request is taken
// only when the previous result beat has left or leaves in the same cycle. The
// list memory needs no clearing after reset: only the head entry of a
// non-empty list is ever used.

module k_way_sorted_union_merge_unit #(
  parameter int unsigned NUM_LISTS  = kwsum_pkg::NUM_LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwsum_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  kwsum_req_if.sink          req_i,
  kwsum_res_if.source        res_o
);
  import kwsum_pkg::*;

  localparam int unsigned LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned HW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW    = LW + HW;
  localparam int unsigned MEM_D = 1 << AW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LOAD = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                state_q;
  logic [LW:0]           sc_q;
  logic                  found_q;
  logic [NUM_LISTS-1:0]  mask_q;
  logic                  lt_q, gt_q;
  logic [DCW-1:0]        dcnt_q;
  logic [HW-1:0]         head_q [NUM_LISTS];
  logic [FW-1:0]         fill_q [NUM_LISTS];

  logic [VAL_W-1:0]      mem [MEM_D];
  logic [VAL_W-1:0]      rdata_q;
  logic [VAL_W-1:0]      best_q, cand_q;
  logic [SHW-1:0]        sh_a_q, sh_b_q;

  logic                  out_valid_q;
  logic [VAL_W-1:0]      out_val_q;
  logic                  out_vres_q;
  logic                  out_ovf_q;

  logic                  req_acc, out_free, out_load;
  logic                  is_push, is_pop, is_clear;
  logic                  push_ok, push_full, push_wr;
  logic [LW-1:0]         push_sel;
  logic [HW:0]           slot_sum;
  logic [HW-1:0]         slot;
  logic [LW-1:0]         sc_idx;
  logic [NUM_LISTS-1:0]  sel_bit;
  logic                  sc_end, sc_nz;
  logic [AW-1:0]         raddr, waddr;
  logic [DIG_W-1:0]      dig_a, dig_b;
  logic                  lt_n, gt_n, last_dig, take_new, tie;

  assign req_acc    = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  // a new result beat is loaded into the output register this cycle
  assign out_load   = ((state_q == S_IDLE) && req_acc && !is_pop) ||
                      ((state_q == S_DONE) && out_free);

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    is_clear = 1'b0;
    unique case (req_i.req_type)
      REQ_PUSH:  is_push  = 1'b1;
      REQ_POP:   is_pop   = 1'b1;
      REQ_CLEAR: is_clear = 1'b1;
      default: ;
    endcase
  end

  // push path: slot = (head + fill) wrapped into the list buffer
  assign push_ok   = int'(req_i.list_index) < int'(NUM_LISTS);
  assign push_sel  = LW'(req_i.list_index);
  assign push_full = fill_q[push_sel] == FW'(LIST_DEPTH);
  assign slot_sum  = (HW+1)'(head_q[push_sel]) + (HW+1)'(fill_q[push_sel]);
  assign slot      = (slot_sum >= (HW+1)'(LIST_DEPTH)) ?
                     HW'(slot_sum - (HW+1)'(LIST_DEPTH)) : HW'(slot_sum);
  assign push_wr   = req_acc && is_push && push_ok && !push_full;
  assign waddr     = {push_sel, slot};

  // scan path
  assign sc_idx  = sc_q[LW-1:0];
  assign sel_bit = NUM_LISTS'(1) << sc_idx;
  assign sc_end  = sc_q == (LW+1)'(NUM_LISTS);
  assign sc_nz   = fill_q[sc_idx] != '0;
  assign raddr   = {sc_idx, head_q[sc_idx]};

  // serial compare of candidate against running minimum, msb digit first
  assign dig_a    = sh_a_q[SHW-1 -: DIG_W];
  assign dig_b    = sh_b_q[SHW-1 -: DIG_W];
  assign lt_n     = lt_q || (!gt_q && (dig_a < dig_b));
  assign gt_n     = gt_q || (!lt_q && (dig_a > dig_b));
  assign last_dig = dcnt_q == DCW'(DIGITS - 1);
  assign take_new = !found_q || lt_n;
  assign tie      = !lt_n && !gt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sc_q        <= '0;
      found_q     <= 1'b0;
      mask_q      <= '0;
      lt_q        <= 1'b0;
      gt_q        <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(NUM_LISTS); i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      if (res_o.ready && !out_load) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            if (is_pop) begin
              found_q <= 1'b0;
              mask_q  <= '0;
              sc_q    <= '0;
              state_q <= S_SCAN;
            end else begin
              out_valid_q <= 1'b1;
            end
            if (push_wr) fill_q[push_sel] <= fill_q[push_sel] + 1'b1;
            if (is_clear) begin
              for (int i = 0; i < int'(NUM_LISTS); i++) begin
                head_q[i] <= '0;
                fill_q[i] <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          if (sc_end) begin
            state_q <= S_DONE;
          end else if (sc_nz) begin
            state_q <= S_LOAD;
          end else begin
            sc_q <= sc_q + 1'b1;
          end
        end
        S_LOAD: begin
          lt_q    <= 1'b0;
          gt_q    <= 1'b0;
          dcnt_q  <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          lt_q   <= lt_n;
          gt_q   <= gt_n;
          dcnt_q <= dcnt_q + 1'b1;
          if (last_dig) begin
            if (take_new) begin
              found_q <= 1'b1;
              mask_q  <= sel_bit;
            end else if (tie) begin
              mask_q <= mask_q | sel_bit;
            end
            sc_q    <= sc_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            // advance every list whose head matched the minimum
            for (int i = 0; i < int'(NUM_LISTS); i++) begin
              if (mask_q[i]) begin
                head_q[i] <= ((HW+1)'(head_q[i]) + 1'b1 == (HW+1)'(LIST_DEPTH)) ?
                             '0 : head_q[i] + 1'b1;
                fill_q[i] <= fill_q[i] - 1'b1;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // list memory: one write port for pushes, one registered read port for scans
  always_ff @(posedge clk_i) begin
    if (push_wr) mem[waddr] <= req_i.value;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      cand_q <= rdata_q;
      sh_a_q <= SHW'(rdata_q);
      sh_b_q <= SHW'(best_q);
    end
    if (state_q == S_CMP) begin
      sh_a_q <= sh_a_q << DIG_W;
      sh_b_q <= sh_b_q << DIG_W;
      if (last_dig && take_new) best_q <= cand_q;
    end
    if (state_q == S_IDLE && req_acc && !is_pop) begin
      out_val_q  <= '0;
      out_vres_q <= 1'b0;
      out_ovf_q  <= is_push && push_ok && push_full;
    end
    if (state_q == S_DONE && out_free) begin
      out_val_q  <= found_q ? best_q : '0;
      out_vres_q <= found_q;
      out_ovf_q  <= 1'b0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.merged_value = out_val_q;
  assign res_o.valid_res    = out_vres_q;
  assign res_o.overflow     = out_ovf_q;

`ifndef NO_ASSERTIONS
  // push and clear deliver their result beat in the next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && !is_pop) |=> out_valid_q)
    else $error("push or clear result not registered");

  // a minimum was found exactly when some list is marked for advance
  a_mask_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (found_q == (mask_q != '0)))
    else $error("advance mask disagrees with found flag");

  // the scan pointer never goes beyond NUM_LISTS, one past the last list
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_q <= (LW+1)'(NUM_LISTS)))
    else $error("scan pointer out of range");
`endif

endmodule
